@@ rtl/tgb_pkg.sv @@
// ----------------------------------------------------------------------------
// tgb_pkg
// Shared constants, codes and helpers of the tetrahedron grid binning block.
// ----------------------------------------------------------------------------
package tgb_pkg;

   // capacity
   localparam int MAX_TETS      = 4096;
   localparam int MAX_GRID_SIDE = 128;
   localparam int MAX_INDICES   = 65536;
   localparam int NCELLS        = MAX_GRID_SIDE * MAX_GRID_SIDE;

   // widths
   localparam int SIDE_W  = $clog2(MAX_GRID_SIDE);
   localparam int GSIDE_W = SIDE_W + 1;
   localparam int CELL_W  = $clog2(NCELLS);
   localparam int NCELL_W = CELL_W + 1;
   localparam int TET_W   = $clog2(MAX_TETS);
   localparam int TETS_W  = TET_W + 1;
   localparam int IDX_W   = $clog2(MAX_INDICES);
   localparam int POS_W   = IDX_W + 1;
   localparam int CNT_W   = 13;
   localparam int RNG_W   = 4 * SIDE_W;
   localparam int CWORD_W = CNT_W + POS_W + CNT_W;

   // cell word layout: count, start, fill
   localparam int CW_CNT_LO   = POS_W + CNT_W;
   localparam int CW_START_LO = CNT_W;

   // request kinds
   localparam logic [2:0] KIND_CLEAR      = 3'd0;
   localparam logic [2:0] KIND_LOAD       = 3'd1;
   localparam logic [2:0] KIND_BUILD      = 3'd2;
   localparam logic [2:0] KIND_READ_CELL  = 3'd3;
   localparam logic [2:0] KIND_READ_INDEX = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_ORIGIN_U    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_V    = 3'd1;
   localparam logic [2:0] CSR_CELL_SIZE_U = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE_V = 3'd3;
   localparam logic [2:0] CSR_CELLS_U     = 3'd4;
   localparam logic [2:0] CSR_CELLS_V     = 3'd5;

   // grid side in use, saturated into 1..MAX_GRID_SIDE
   function automatic logic [GSIDE_W-1:0] grid_side(input logic [7:0] n);
      logic [GSIDE_W-1:0] r;
      if (n == 8'd0) begin
         r = GSIDE_W'(1);
      end else if (32'(n) > MAX_GRID_SIDE) begin
         r = GSIDE_W'(MAX_GRID_SIDE);
      end else begin
         r = GSIDE_W'(n);
      end
      return r;
   endfunction

endpackage

@@ rtl/tgb_div.sv @@
// ----------------------------------------------------------------------------
// tgb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [31:0] trial;

   // one shift and trial subtract per cycle
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      trial     = {rem_ff[30:0], quo_ff[31]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 5'd0;
         rem_in    = 32'd0;
         quo_in    = dividend;
         dvs_in    = divisor;
      end else if (active_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= 5'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/tet_grid_binning_top.sv @@
// ----------------------------------------------------------------------------
// tet_grid_binning_top
// Uniform 2D grid binning of projected tetrahedra with a counting sort.
// ----------------------------------------------------------------------------
// Use: one request word on req_* (valid/stall). Clear, load and build give
// no response word; read cell and read index give one word on rsp_*.
// Registers are written through csr_*; write them only while the block is idle, the block itself does not enforce it.
// Work per request, done in steps by the sequencer on the cell memory:
//   load        four divisions on the shared serial divider, then a count
//               increment in each covered cell
//   build       prefix pass over the grid cells, then a scatter pass over
//               the loaded tetrahedra and their covered cells
//   read        one memory read into the response register
//   clear       pass over the cell memory that zeroes counts and fills and keeps the starts
//   full load   word dropped and flag set when the store is full
//   other kinds ignored
// Reset starts a zeroing pass over all cell entries; no request word is
// taken until it ends, register writes are taken always.
// The response register holds its word while rsp_stall is high; a read
// that finishes while it is still full waits for it to drain.
// ----------------------------------------------------------------------------
module tet_grid_binning_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_kind,
   input  logic signed [31:0]          req_corner0_u,
   input  logic signed [31:0]          req_corner0_v,
   input  logic signed [31:0]          req_corner1_u,
   input  logic signed [31:0]          req_corner1_v,
   input  logic signed [31:0]          req_corner2_u,
   input  logic signed [31:0]          req_corner2_v,
   input  logic signed [31:0]          req_corner3_u,
   input  logic signed [31:0]          req_corner3_v,
   input  logic [15:0]                 req_address,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [16:0]                 rsp_first_position,
   output logic [12:0]                 rsp_entry_count,
   output logic [11:0]                 rsp_tet_number,
   output logic                        rsp_overflow,
   // register port
   input  logic                        csr_write_enable,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_write_data
);

   localparam int SW  = tgb_pkg::SIDE_W;
   localparam int GW  = tgb_pkg::GSIDE_W;
   localparam int CW  = tgb_pkg::CELL_W;
   localparam int NW  = tgb_pkg::NCELL_W;
   localparam int TW  = tgb_pkg::TET_W;
   localparam int TSW = tgb_pkg::TETS_W;
   localparam int IW  = tgb_pkg::IDX_W;
   localparam int PW  = tgb_pkg::POS_W;
   localparam int KW  = tgb_pkg::CNT_W;
   localparam int RW  = tgb_pkg::RNG_W;
   localparam int WW  = tgb_pkg::CWORD_W;
   localparam int CL  = tgb_pkg::CW_CNT_LO;
   localparam int SL  = tgb_pkg::CW_START_LO;

   typedef enum logic [13:0] {
      S_CLR   = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_DIV   = 14'b00000000000100,
      S_CLAMP = 14'b00000000001000,
      S_LRD   = 14'b00000000010000,
      S_LWR   = 14'b00000000100000,
      S_PRD   = 14'b00000001000000,
      S_PWR   = 14'b00000010000000,
      S_TRD   = 14'b00000100000000,
      S_TCHK  = 14'b00001000000000,
      S_CRD   = 14'b00010000000000,
      S_CWR   = 14'b00100000000000,
      S_RISS  = 14'b01000000000000,
      S_RRES  = 14'b10000000000000
   } state_type;

   // clamp one axis: {empty, lo, hi}
   function automatic logic [2*SW:0] clamp_axis(
      input logic        lo_neg,
      input logic [31:0] lo_mag,
      input logic        hi_neg,
      input logic [31:0] hi_mag,
      input logic [GW-1:0] n
   );
      logic [GW-1:0] nm1;
      logic [SW-1:0] lo_c, hi_c;
      logic          lo_big, empty;
      nm1    = n - GW'(1);
      lo_big = !lo_neg && (lo_mag > 32'(nm1));
      lo_c   = lo_neg ? SW'(0) : lo_mag[SW-1:0];
      hi_c   = (hi_mag >= 32'(n)) ? nm1[SW-1:0] : hi_mag[SW-1:0];
      empty  = hi_neg || lo_big || (lo_c > hi_c);
      return {empty, lo_c, hi_c};
   endfunction

   // configuration
   logic [31:0] org_u_ff, org_v_ff;
   logic [30:0] size_u_ff, size_v_ff;
   logic [7:0]  cells_u_ff, cells_v_ff;
   logic [GW-1:0] cu, cv;
   logic [NW-1:0] ncell;

   // sequencer state
   state_type     state_ff, state_in;
   logic [15:0]   addr_ff, addr_in;
   logic          is_index_ff, is_index_in;
   logic          keep_ff, keep_in;
   logic [32:0]   d_ff [4];
   logic [32:0]   d_in [4];
   logic [3:0]    qneg_ff, qneg_in;
   logic [31:0]   qmag_ff [4];
   logic [31:0]   qmag_in [4];
   logic [1:0]    sel_ff, sel_in;
   logic          div_start_ff, div_start_in;
   logic [TSW-1:0] tets_ff, tets_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] r_ff, r_in, c_ff, c_in;
   logic [SW-1:0] cmin_ff, cmin_in, rmax_ff, rmax_in, cmax_ff, cmax_in;
   logic [CW-1:0] cell_addr_ff, cell_addr_in;
   logic [NW-1:0] i_ff, i_in;
   logic [PW-1:0] total_ff, total_in;
   logic [TSW-1:0] t_ff, t_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [16:0]   rsp_fp_ff, rsp_fp_in;
   logic [12:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [11:0]   rsp_tet_ff, rsp_tet_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // memories
   logic [WW-1:0] cell_mem [tgb_pkg::NCELLS];
   logic [WW-1:0] cell_rd_ff;
   logic          cm_we, cm_re;
   logic [CW-1:0] cm_waddr, cm_raddr;
   logic [WW-1:0] cm_wdata;
   logic [RW-1:0] rng_mem [tgb_pkg::MAX_TETS];
   logic [RW-1:0] rng_rd_ff;
   logic          rg_we, rg_re;
   logic [TW-1:0] rg_waddr, rg_raddr;
   logic [RW-1:0] rg_wdata;
   logic [TW-1:0] idx_mem [tgb_pkg::MAX_INDICES];
   logic [TW-1:0] idx_rd_ff;
   logic          ix_we, ix_re;
   logic [IW-1:0] ix_waddr, ix_raddr;
   logic [TW-1:0] ix_wdata;

   // helpers
   logic          accept;
   logic signed [31:0] umn, umx, vmn, vmx;
   logic [32:0]   dsel;
   logic [31:0]   div_dividend;
   logic [30:0]   div_divisor;
   logic          div_done;
   logic [31:0]   div_q;
   logic [CW-1:0] cell_lin;
   logic [2*SW:0] ax_u, ax_v;
   logic          walk_last, last_tet;
   logic [KW-1:0] rd_cnt, rd_fill;
   logic [PW-1:0] rd_start, p_start;
   logic [PW:0]   p_sum, pos;
   logic [SW-1:0] tr_umin, tr_umax, tr_vmin, tr_vmax;
   logic          tr_skip;

   assign cu    = tgb_pkg::grid_side(cells_u_ff);
   assign cv    = tgb_pkg::grid_side(cells_v_ff);
   assign ncell = NW'(cu * cv);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // bounding box of the four corners
   always_comb begin
      umn = req_corner0_u;
      umx = req_corner0_u;
      vmn = req_corner0_v;
      vmx = req_corner0_v;
      if (req_corner1_u < umn) umn = req_corner1_u;
      if (req_corner2_u < umn) umn = req_corner2_u;
      if (req_corner3_u < umn) umn = req_corner3_u;
      if (req_corner1_u > umx) umx = req_corner1_u;
      if (req_corner2_u > umx) umx = req_corner2_u;
      if (req_corner3_u > umx) umx = req_corner3_u;
      if (req_corner1_v < vmn) vmn = req_corner1_v;
      if (req_corner2_v < vmn) vmn = req_corner2_v;
      if (req_corner3_v < vmn) vmn = req_corner3_v;
      if (req_corner1_v > vmx) vmx = req_corner1_v;
      if (req_corner2_v > vmx) vmx = req_corner2_v;
      if (req_corner3_v > vmx) vmx = req_corner3_v;
   end

   // divider operands: magnitude of offset, cell size with zero as one
   assign dsel         = d_ff[sel_ff];
   assign div_dividend = dsel[32] ? 32'(~dsel + 33'd1) : dsel[31:0];
   always_comb begin
      div_divisor = sel_ff[1] ? size_v_ff : size_u_ff;
      if (div_divisor == 31'd0) div_divisor = 31'd1;
   end

   tgb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // walk helpers
   assign cell_lin  = CW'(r_ff * cv) + CW'(c_ff);
   assign walk_last = (c_ff == cmax_ff) && (r_ff == rmax_ff);
   assign last_tet  = (TSW'(t_ff + TSW'(1)) == tets_ff);
   assign ax_u = clamp_axis(qneg_ff[0], qmag_ff[0], qneg_ff[1], qmag_ff[1], cu);
   assign ax_v = clamp_axis(qneg_ff[2], qmag_ff[2], qneg_ff[3], qmag_ff[3], cv);

   // cell word fields
   assign rd_cnt   = cell_rd_ff[CL +: KW];
   assign rd_start = cell_rd_ff[SL +: PW];
   assign rd_fill  = cell_rd_ff[0 +: KW];
   assign p_start  = (32'(total_ff) < tgb_pkg::MAX_INDICES) ? total_ff
                                                             : PW'(tgb_pkg::MAX_INDICES);
   assign p_sum    = {1'b0, total_ff} + (PW+1)'(rd_cnt);
   assign pos      = {1'b0, rd_start} + (PW+1)'(rd_fill);

   // stored range fields
   assign tr_umin = rng_rd_ff[3*SW +: SW];
   assign tr_umax = rng_rd_ff[2*SW +: SW];
   assign tr_vmin = rng_rd_ff[SW +: SW];
   assign tr_vmax = rng_rd_ff[0 +: SW];
   assign tr_skip = (tr_umin > tr_umax) || (tr_vmin > tr_vmax)
                 || (GW'(tr_umin) >= cu) || (GW'(tr_vmin) >= cv);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      is_index_in  = is_index_ff;
      keep_in      = keep_ff;
      d_in         = d_ff;
      qneg_in      = qneg_ff;
      qmag_in      = qmag_ff;
      sel_in       = sel_ff;
      div_start_in = 1'b0;
      tets_in      = tets_ff;
      ovf_in       = ovf_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      cmin_in      = cmin_ff;
      rmax_in      = rmax_ff;
      cmax_in      = cmax_ff;
      cell_addr_in = cell_addr_ff;
      i_in         = i_ff;
      total_in     = total_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_fp_in    = rsp_fp_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_tet_in   = rsp_tet_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      cm_we = 1'b0; cm_re = 1'b0;
      cm_waddr = cell_addr_ff; cm_raddr = cell_lin; cm_wdata = cell_rd_ff;
      rg_we = 1'b0; rg_re = 1'b0;
      rg_waddr = tets_ff[TW-1:0]; rg_raddr = t_ff[TW-1:0];
      rg_wdata = {ax_u[2*SW-1:0], ax_v[2*SW-1:0]};
      ix_we = 1'b0; ix_re = 1'b0;
      ix_waddr = pos[IW-1:0]; ix_raddr = addr_ff; ix_wdata = t_ff[TW-1:0];

      unique case (state_ff)
         // clearing pass over the cell memory
         S_CLR: begin
            if (keep_ff) begin
               // clear command: read entry i, write back entry i-1 with its start
               cm_re    = 1'b1;
               cm_raddr = i_ff[CW-1:0];
               cm_we    = (i_ff != '0);
               cm_waddr = CW'(i_ff - NW'(1));
               cm_wdata = {KW'(0), rd_start, KW'(0)};
               if (i_ff == NW'(tgb_pkg::NCELLS)) begin
                  i_in     = '0;
                  keep_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + NW'(1);
               end
            end else begin
               cm_we    = 1'b1;
               cm_waddr = i_ff[CW-1:0];
               cm_wdata = '0;
               if (i_ff[CW-1:0] == CW'(tgb_pkg::NCELLS - 1)) begin
                  i_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + NW'(1);
               end
            end
         end
         // request decode
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  tgb_pkg::KIND_CLEAR: begin
                     tets_in  = '0;
                     ovf_in   = 1'b0;
                     i_in     = '0;
                     keep_in  = 1'b1;
                     state_in = S_CLR;
                  end
                  tgb_pkg::KIND_LOAD: begin
                     if (32'(tets_ff) >= tgb_pkg::MAX_TETS) begin
                        ovf_in = 1'b1;
                     end else begin
                        d_in[0] = {umn[31], umn} - {org_u_ff[31], org_u_ff};
                        d_in[1] = {umx[31], umx} - {org_u_ff[31], org_u_ff};
                        d_in[2] = {vmn[31], vmn} - {org_v_ff[31], org_v_ff};
                        d_in[3] = {vmx[31], vmx} - {org_v_ff[31], org_v_ff};
                        sel_in       = 2'd0;
                        div_start_in = 1'b1;
                        state_in     = S_DIV;
                     end
                  end
                  tgb_pkg::KIND_BUILD: begin
                     i_in     = '0;
                     total_in = '0;
                     state_in = S_PRD;
                  end
                  tgb_pkg::KIND_READ_CELL: begin
                     addr_in     = req_address;
                     is_index_in = 1'b0;
                     state_in    = S_RISS;
                  end
                  tgb_pkg::KIND_READ_INDEX: begin
                     addr_in     = req_address;
                     is_index_in = 1'b1;
                     state_in    = S_RISS;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // four divisions on the shared divider
         S_DIV: begin
            if (div_done) begin
               qneg_in[sel_ff] = dsel[32] && (div_q != 32'd0);
               qmag_in[sel_ff] = div_q;
               if (sel_ff == 2'd3) begin
                  state_in = S_CLAMP;
               end else begin
                  sel_in       = sel_ff + 2'd1;
                  div_start_in = 1'b1;
               end
            end
         end
         // clamp, store the range, start the count walk if the range is not empty
         S_CLAMP: begin
            rg_we   = 1'b1;
            tets_in = tets_ff + TSW'(1);
            if (ax_u[2*SW] || ax_v[2*SW]) begin
               rg_wdata = {{SW{1'b1}}, SW'(0), {SW{1'b1}}, SW'(0)};
               state_in = S_IDLE;
            end else begin
               r_in     = ax_u[2*SW-1:SW];
               rmax_in  = ax_u[SW-1:0];
               c_in     = ax_v[2*SW-1:SW];
               cmin_in  = ax_v[2*SW-1:SW];
               cmax_in  = ax_v[SW-1:0];
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            cm_re        = 1'b1;
            cell_addr_in = cell_lin;
            state_in     = S_LWR;
         end
         // count increment write-back
         S_LWR: begin
            cm_we    = 1'b1;
            cm_wdata = {KW'(rd_cnt + KW'(1)), cell_rd_ff[CL-1:0]};
            if (walk_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_LRD;
               if (c_ff == cmax_ff) begin
                  c_in = cmin_ff;
                  r_in = r_ff + SW'(1);
               end else begin
                  c_in = c_ff + SW'(1);
               end
            end
         end
         // prefix pass
         S_PRD: begin
            cm_re    = 1'b1;
            cm_raddr = i_ff[CW-1:0];
            state_in = S_PWR;
         end
         S_PWR: begin
            cm_we    = 1'b1;
            cm_waddr = i_ff[CW-1:0];
            cm_wdata = {rd_cnt, p_start, KW'(0)};
            total_in = (32'(p_sum) > tgb_pkg::MAX_INDICES)
                     ? PW'(tgb_pkg::MAX_INDICES + 1) : p_sum[PW-1:0];
            if (i_ff == ncell - NW'(1)) begin
               t_in     = '0;
               state_in = (tets_ff == '0) ? S_IDLE : S_TRD;
            end else begin
               i_in     = i_ff + NW'(1);
               state_in = S_PRD;
            end
         end
         // scatter pass
         S_TRD: begin
            rg_re    = 1'b1;
            state_in = S_TCHK;
         end
         S_TCHK: begin
            if (tr_skip) begin
               t_in     = t_ff + TSW'(1);
               state_in = last_tet ? S_IDLE : S_TRD;
            end else begin
               r_in     = tr_umin;
               c_in     = tr_vmin;
               cmin_in  = tr_vmin;
               rmax_in  = (GW'(tr_umax) >= cu) ? SW'(cu - GW'(1)) : tr_umax;
               cmax_in  = (GW'(tr_vmax) >= cv) ? SW'(cv - GW'(1)) : tr_vmax;
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            cm_re        = 1'b1;
            cell_addr_in = cell_lin;
            state_in     = S_CWR;
         end
         S_CWR: begin
            if ((rd_fill >= rd_cnt) || (32'(pos) >= tgb_pkg::MAX_INDICES)) begin
               ovf_in = 1'b1;
            end else begin
               ix_we    = 1'b1;
               cm_we    = 1'b1;
               cm_wdata = {cell_rd_ff[WW-1:KW], KW'(rd_fill + KW'(1))};
            end
            if (walk_last) begin
               t_in     = t_ff + TSW'(1);
               state_in = last_tet ? S_IDLE : S_TRD;
            end else begin
               state_in = S_CRD;
               if (c_ff == cmax_ff) begin
                  c_in = cmin_ff;
                  r_in = r_ff + SW'(1);
               end else begin
                  c_in = c_ff + SW'(1);
               end
            end
         end
         // reads
         S_RISS: begin
            if (is_index_ff) begin
               ix_re = 1'b1;
            end else begin
               cm_re    = 1'b1;
               cm_raddr = addr_ff[CW-1:0];
            end
            state_in = S_RRES;
         end
         S_RRES: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_fp_in    = '0;
               rsp_cnt_in   = '0;
               rsp_tet_in   = '0;
               if (is_index_ff) begin
                  rsp_tet_in = idx_rd_ff;
               end else if (NW'(addr_ff) < ncell && addr_ff < 16'(tgb_pkg::NCELLS)) begin
                  rsp_fp_in  = rd_start;
                  rsp_cnt_in = rd_cnt;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         i_ff         <= '0;
         keep_ff      <= 1'b0;
         tets_ff      <= '0;
         ovf_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         keep_ff      <= keep_in;
         tets_ff      <= tets_in;
         ovf_ff       <= ovf_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      is_index_ff  <= is_index_in;
      d_ff         <= d_in;
      qneg_ff      <= qneg_in;
      qmag_ff      <= qmag_in;
      sel_ff       <= sel_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      cmin_ff      <= cmin_in;
      rmax_ff      <= rmax_in;
      cmax_ff      <= cmax_in;
      cell_addr_ff <= cell_addr_in;
      total_ff     <= total_in;
      t_ff         <= t_in;
      rsp_fp_ff    <= rsp_fp_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_tet_ff   <= rsp_tet_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         org_u_ff   <= 32'd0;
         org_v_ff   <= 32'd0;
         size_u_ff  <= 31'd65536;
         size_v_ff  <= 31'd65536;
         cells_u_ff <= 8'd100;
         cells_v_ff <= 8'd100;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tgb_pkg::CSR_ORIGIN_U:    org_u_ff   <= csr_write_data;
            tgb_pkg::CSR_ORIGIN_V:    org_v_ff   <= csr_write_data;
            tgb_pkg::CSR_CELL_SIZE_U: size_u_ff  <= csr_write_data[30:0];
            tgb_pkg::CSR_CELL_SIZE_V: size_v_ff  <= csr_write_data[30:0];
            tgb_pkg::CSR_CELLS_U:     cells_u_ff <= csr_write_data[7:0];
            tgb_pkg::CSR_CELLS_V:     cells_v_ff <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // cell memory: count, start, fill
   always_ff @(posedge clock) begin
      if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
      if (cm_re) cell_rd_ff <= cell_mem[cm_raddr];
   end

   // range memory
   always_ff @(posedge clock) begin
      if (rg_we) rng_mem[rg_waddr] <= rg_wdata;
      if (rg_re) rng_rd_ff <= rng_mem[rg_raddr];
   end

   // index store
   always_ff @(posedge clock) begin
      if (ix_we) idx_mem[ix_waddr] <= ix_wdata;
      if (ix_re) idx_rd_ff <= idx_mem[ix_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_position = rsp_fp_ff;
   assign rsp_entry_count    = rsp_cnt_ff;
   assign rsp_tet_number     = rsp_tet_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule
